// ===== rtl/core/cusbrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cusbrd_pkg: shared types and constants of the CAN receive record decoder
// Holds the channel word types, the record and filter structs, register
// indexes and the status codes carried in status records.
// ----------------------------------------------------------------------------
package cusbrd_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned POS_W = 5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       transfer_end;
  } in_word_t;

  typedef struct packed {
    logic        delivered;
    logic        is_extended;
    logic        is_remote;
    logic        is_status;
    logic [31:0] frame_id;
    logic [7:0]  length_code;
    logic [63:0] payload;
    logic [31:0] hw_timestamp;
    logic        warning_flag;
    logic        bus_off_flag;
    logic        bus_error_flag;
  } out_word_t;

  typedef struct packed {
    logic        is_extended;
    logic        is_remote;
    logic        is_status;
    logic [31:0] frame_id;
    logic [7:0]  length_code;
    logic [63:0] payload;
    logic [31:0] hw_timestamp;
  } record_t;

  typedef struct packed {
    logic drop_extended;
    logic drop_remote;
    logic drop_status;
  } filter_cfg_t;

  typedef enum logic [1:0] {
    CFG_DROP_EXTENDED = 2'd0,
    CFG_DROP_REMOTE   = 2'd1,
    CFG_DROP_STATUS   = 2'd2
  } cfg_index_t;

  localparam logic [7:0] ST_CLEAR_ALL  = 8'h00;
  localparam logic [7:0] ST_WARN_CLEAR = 8'h02;
  localparam logic [7:0] ST_WARN_SET   = 8'h03;
  localparam logic [7:0] ST_BUS_OFF    = 8'h04;
  localparam logic [7:0] ST_ERR_A      = 8'h20;
  localparam logic [7:0] ST_ERR_B      = 8'h21;
  localparam logic [7:0] ST_ERR_C      = 8'h23;
  localparam logic [7:0] ST_ERR_D      = 8'h24;
  localparam logic [7:0] ST_ERR_E      = 8'h25;
  localparam logic [7:0] ST_ERR_F      = 8'h27;

endpackage
`default_nettype wire

// ===== rtl/core/cusbrd_assembler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cusbrd_assembler: record assembly from the receive byte stream
// Tracks the byte position within a record, collects the fields in shift
// registers and presents the finished record on the word of its last byte.
// ----------------------------------------------------------------------------
module cusbrd_assembler #(
  parameter int unsigned PAYLOAD_BYTES = cusbrd_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire cusbrd_pkg::in_word_t in_word,
  output logic                     rec_valid,
  output cusbrd_pkg::record_t      rec
);
  import cusbrd_pkg::*;

  localparam int unsigned REC_LEN = 10 + PAYLOAD_BYTES;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(REC_LEN - 1);
  localparam logic [POS_W-1:0] STAMP_POS = POS_W'(6 + PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] LEN_POS = POS_W'(5);
  localparam int unsigned PAY_SHIFT = 8 * (8 - PAYLOAD_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt, pos;
  logic [2:0]       flags_r;
  logic [31:0]      id_r;
  logic [7:0]       len_r;
  logic [63:0]      pay_r;
  logic [23:0]      stamp_r;
  logic             last;

  assign pos  = (pos_r > LAST_POS) ? '0 : pos_r;
  assign last = (pos == LAST_POS);
  assign pos_nxt = (last || in_word.transfer_end) ? '0 : pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == '0) begin
        flags_r <= in_word.rx_byte[2:0];
      end else if (pos < LEN_POS) begin
        id_r <= {id_r[23:0], in_word.rx_byte};
      end else if (pos == LEN_POS) begin
        len_r <= in_word.rx_byte;
      end else if (pos < STAMP_POS) begin
        pay_r <= {pay_r[55:0], in_word.rx_byte};
      end else if (!last) begin
        stamp_r <= {stamp_r[15:0], in_word.rx_byte};
      end
    end
  end

  assign rec_valid        = accept && last;
  assign rec.is_extended  = flags_r[0];
  assign rec.is_remote    = flags_r[1];
  assign rec.is_status    = flags_r[2];
  assign rec.frame_id     = id_r;
  assign rec.length_code  = len_r;
  assign rec.payload      = pay_r << PAY_SHIFT;
  assign rec.hw_timestamp = {stamp_r, in_word.rx_byte};

endmodule
`default_nettype wire

// ===== rtl/core/cusbrd_result.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cusbrd_result: bus status tracking, delivery filter and result register
// Updates the sticky bus status from status records, applies the suppress
// rules and holds the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module cusbrd_result (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rec_valid,
  input  wire cusbrd_pkg::record_t    rec,
  input  wire cusbrd_pkg::filter_cfg_t filt,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output cusbrd_pkg::out_word_t       out_word
);
  import cusbrd_pkg::*;

  logic [2:0] bus_r, bus_nxt, bus_upd;
  logic       out_valid_r;
  out_word_t  out_word_r;
  logic       keep;

  always_comb begin
    bus_upd = bus_r;
    case (rec.payload[63:56])
      ST_CLEAR_ALL:  bus_upd = 3'b000;
      ST_WARN_CLEAR: bus_upd = bus_r & 3'b110;
      ST_WARN_SET:   bus_upd = bus_r | 3'b001;
      ST_BUS_OFF:    bus_upd = bus_r | 3'b010;
      ST_ERR_A, ST_ERR_B, ST_ERR_C, ST_ERR_D, ST_ERR_E, ST_ERR_F:
                     bus_upd = bus_r | 3'b100;
      default:       bus_upd = bus_r;
    endcase
  end

  assign bus_nxt = (rec.is_status && (rec.length_code != 8'h00)) ? bus_upd : bus_r;

  assign keep = !((rec.is_extended && filt.drop_extended) ||
                  (rec.is_remote && filt.drop_remote) ||
                  (rec.is_status && filt.drop_status));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (rec_valid) begin
      bus_r       <= bus_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      out_word_r.delivered      <= keep;
      out_word_r.is_extended    <= rec.is_extended;
      out_word_r.is_remote      <= rec.is_remote;
      out_word_r.is_status      <= rec.is_status;
      out_word_r.frame_id       <= rec.frame_id;
      out_word_r.length_code    <= rec.length_code;
      out_word_r.payload        <= rec.payload;
      out_word_r.hw_timestamp   <= rec.hw_timestamp;
      out_word_r.warning_flag   <= bus_nxt[0];
      out_word_r.bus_off_flag   <= bus_nxt[1];
      out_word_r.bus_error_flag <= bus_nxt[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== rtl/core/can_usb_rx_record_decoder_core.sv =====
`default_nettype none
// A result word is registered and appears in the cycle after the last byte of its record is accepted.
// Throughput: one byte per cycle; input stalls only while a result word is
// held in the output register and not taken in the same cycle.
// Reset (synchronous, active low) clears the byte position, the bus status,
// the result valid flag and sets the suppress registers to their defaults.
// ----------------------------------------------------------------------------
// can_usb_rx_record_decoder_core: CAN receive record decoder, top level
// Cuts the USB receive byte stream into fixed-size CAN records and delivers
// the decoded fields with the sticky bus status after each record.
// ----------------------------------------------------------------------------
module can_usb_rx_record_decoder_core #(
  parameter int unsigned PAYLOAD_BYTES = cusbrd_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cusbrd_pkg::in_word_t  in_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cusbrd_pkg::out_word_t      out_word,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic                  cfg_wdata
);
  import cusbrd_pkg::*;

  filter_cfg_t filt_r;
  record_t     rec;
  logic        rec_valid;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r.drop_extended <= 1'b0;
      filt_r.drop_remote   <= 1'b0;
      filt_r.drop_status   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DROP_EXTENDED: filt_r.drop_extended <= cfg_wdata;
        CFG_DROP_REMOTE:   filt_r.drop_remote   <= cfg_wdata;
        CFG_DROP_STATUS:   filt_r.drop_status   <= cfg_wdata;
        default:           filt_r <= filt_r;
      endcase
    end
  end

  cusbrd_assembler #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_assembler (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .rec_valid(rec_valid),
    .rec      (rec)
  );

  cusbrd_result u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_valid(rec_valid),
    .rec      (rec),
    .filt     (filt_r),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

// ===== rtl/core/cusbrd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cusbrd_checker: port-level checks for the CAN receive record decoder
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module cusbrd_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire cusbrd_pkg::out_word_t out_word
);
  import cusbrd_pkg::*;

  // A result word must not move or vanish while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid set after reset");

  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted byte");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

bind can_usb_rx_record_decoder_core cusbrd_checker u_cusbrd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
`default_nettype wire

// ===== verif/can_usb_rx_record_decoder_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// can_usb_rx_record_decoder_core_test: self-checking bench for the decoder
// Streams USB receive bytes into the decoder, predicts every record result
// with a cycle-free decoder model, and compares each result word field by
// field. Directed records cover the field extremes, every status code and
// the transfer-end cases. Random traffic mixes whole records, cut records
// and noise under several filter settings, random stalls on both channels,
// a long output hold-off and quiet phases with no stalls.
// ----------------------------------------------------------------------------
module can_usb_rx_record_decoder_core_test;
  import cusbrd_pkg::*;

  localparam int unsigned REC_BYTES = 18;
  localparam int unsigned STAMP_POS = 14;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
  localparam logic [7:0] ST_OVERRUN = 8'h01;
  localparam logic [7:0] STATUS_CODES [11] = '{ST_WARN_SET, ST_BUS_OFF, ST_OVERRUN,
    ST_WARN_CLEAR, ST_ERR_A, ST_ERR_B, ST_ERR_C, ST_ERR_D, ST_ERR_E, ST_ERR_F, ST_CLEAR_ALL};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic cfg_wdata = 1'b0;

  in_word_t pending_bytes[$];
  out_word_t expected_records[$];

  int unsigned send_gap = 0;
  int unsigned send_gap_max = 12;
  int unsigned recv_wait = 0;
  int unsigned recv_gap_max = 12;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;
  int errors = 0;

  filter_cfg_t filter = '{drop_extended: 1'b0, drop_remote: 1'b0, drop_status: 1'b1};
  logic [4:0] rec_pos = '0;
  logic [2:0] rec_flags = '0;
  logic [31:0] rec_id = '0;
  logic [7:0] rec_len = '0;
  logic [63:0] rec_payload = '0;
  logic [23:0] rec_stamp_hi = '0;
  logic bus_warn = 1'b0;
  logic bus_off = 1'b0;
  logic bus_err = 1'b0;

  can_usb_rx_record_decoder_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic decode_byte(input in_word_t w);
    out_word_t r;
    logic [4:0] pos;
    logic [7:0] b;
    b = w.rx_byte;
    pos = (rec_pos >= REC_BYTES) ? '0 : rec_pos;
    if (pos == 0) begin
      rec_flags = b[2:0];
      rec_id = '0;
      rec_payload = '0;
    end else if (pos <= 4) begin
      rec_id = {rec_id[23:0], b};
    end else if (pos == 5) begin
      rec_len = b;
    end else if (pos < STAMP_POS) begin
      rec_payload = {rec_payload[55:0], b};
    end else if (pos < REC_BYTES - 1) begin
      rec_stamp_hi = {rec_stamp_hi[15:0], b};
    end
    if (pos < REC_BYTES - 1) begin
      rec_pos = w.transfer_end ? '0 : pos + 5'd1;
    end else begin
      rec_pos = '0;
      if (rec_flags[2] && rec_len != 0) begin
        case (rec_payload[63:56])
          ST_CLEAR_ALL: begin
            bus_warn = 1'b0;
            bus_off = 1'b0;
            bus_err = 1'b0;
          end
          ST_WARN_CLEAR: bus_warn = 1'b0;
          ST_WARN_SET: bus_warn = 1'b1;
          ST_BUS_OFF: bus_off = 1'b1;
          ST_ERR_A, ST_ERR_B, ST_ERR_C, ST_ERR_D, ST_ERR_E, ST_ERR_F: bus_err = 1'b1;
          default: ;
        endcase
      end
      r.delivered = !((rec_flags[0] && filter.drop_extended) ||
                      (rec_flags[1] && filter.drop_remote) ||
                      (rec_flags[2] && filter.drop_status));
      r.is_extended = rec_flags[0];
      r.is_remote = rec_flags[1];
      r.is_status = rec_flags[2];
      r.frame_id = rec_id;
      r.length_code = rec_len;
      r.payload = rec_payload;
      r.hw_timestamp = {rec_stamp_hi, b};
      r.warning_flag = bus_warn;
      r.bus_off_flag = bus_off;
      r.bus_error_flag = bus_err;
      expected_records.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_record(input out_word_t got);
    out_word_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
    end else begin
      want = expected_records.pop_front();
      check_field("delivered", 64'(want.delivered), 64'(got.delivered));
      check_field("is_extended", 64'(want.is_extended), 64'(got.is_extended));
      check_field("is_remote", 64'(want.is_remote), 64'(got.is_remote));
      check_field("is_status", 64'(want.is_status), 64'(got.is_status));
      check_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
      check_field("length_code", 64'(want.length_code), 64'(got.length_code));
      check_field("payload", want.payload, got.payload);
      check_field("hw_timestamp", 64'(want.hw_timestamp), 64'(got.hw_timestamp));
      check_field("warning_flag", 64'(want.warning_flag), 64'(got.warning_flag));
      check_field("bus_off_flag", 64'(want.bus_off_flag), 64'(got.bus_off_flag));
      check_field("bus_error_flag", 64'(want.bus_error_flag), 64'(got.bus_error_flag));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_word);
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_word <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    int unsigned w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      check_record(out_word);
      if (hold_requests != holds_done) begin
        holds_done <= holds_done + 1;
        recv_wait <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        w = $urandom_range(0, recv_gap_max);
        recv_wait <= w;
        out_ready <= (w == 0);
      end
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_record(input logic [7:0] flags, input logic [31:0] id,
                              input logic [7:0] len, input logic [63:0] payload,
                              input logic [31:0] stamp, input int unsigned n_bytes,
                              input bit end_last);
    logic [143:0] rec;
    in_word_t w;
    rec = {flags, id, len, payload, stamp};
    for (int i = 0; i < n_bytes; i++) begin
      w.rx_byte = rec[143 - 8 * i -: 8];
      w.transfer_end = end_last && (i == n_bytes - 1);
      pending_bytes.push_back(w);
    end
  endtask

  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned queued;
    int unsigned kind;
    int unsigned k;
    logic [7:0] flags;
    logic [7:0] len;
    logic [63:0] pay;
    in_word_t w;
    queued = 0;
    while (queued < n_bytes) begin
      kind = $urandom_range(0, 9);
      flags = 8'($urandom);
      if ($urandom_range(0, 2) == 0) flags[2] = 1'b1;
      len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      pay = {$urandom, $urandom};
      if (flags[2] && $urandom_range(0, 1) == 1) begin
        pay[63:56] = STATUS_CODES[$urandom_range(0, 10)];
      end
      if (kind <= 6) begin
        queue_record(flags, $urandom, len, pay, $urandom, REC_BYTES,
                     1'($urandom_range(0, 1)));
        queued += REC_BYTES;
      end else if (kind <= 8) begin
        k = $urandom_range(1, REC_BYTES - 1);
        queue_record(flags, $urandom, len, pay, $urandom, k, 1'b1);
        queued += k;
      end else begin
        k = $urandom_range(1, 20);
        for (int i = 0; i < k; i++) begin
          w.rx_byte = 8'($urandom);
          w.transfer_end = (i == k - 1) || ($urandom_range(0, 3) == 0);
          pending_bytes.push_back(w);
        end
        queued += k;
      end
    end
  endtask

  task automatic write_filter(input logic [1:0] idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DROP_EXTENDED: filter.drop_extended = val;
      CFG_DROP_REMOTE: filter.drop_remote = val;
      CFG_DROP_STATUS: filter.drop_status = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned choice;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes under the reset filter settings.
    queue_record(8'h00, 32'h0, 8'h00, 64'h0, 32'h0, REC_BYTES, 1'b0);
    queue_record(8'hFF, 32'hFFFF_FFFF, 8'hFF, '1, 32'hFFFF_FFFF, REC_BYTES, 1'b1);
    queue_record(8'hF8, 32'h1234_5678, 8'h08, 64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF,
                 REC_BYTES, 1'b0);
    queue_record(8'h01, 32'h1FFF_FFFF, 8'h04, 64'hA5A5_5A5A_0000_FFFF, 32'h0000_0001,
                 REC_BYTES, 1'b0);
    queue_record(8'h02, 32'h0000_07FF, 8'h00, 64'h0, 32'h8000_0000, REC_BYTES, 1'b1);
    // Every status code, then a zero-length status record that must not act and one that must.
    for (int i = 0; i < 11; i++) begin
      queue_record(8'h04, 32'h0, 8'h01, {STATUS_CODES[i], 56'h11_2233_4455_6677},
                   32'h1000 + i, REC_BYTES, 1'b0);
    end
    queue_record(8'h04, 32'h0, 8'h00, {ST_WARN_SET, 56'h0}, 32'h2000, REC_BYTES, 1'b0);
    queue_record(8'h04, 32'h0, 8'h02, {ST_WARN_SET, 56'h0}, 32'h2001, REC_BYTES, 1'b1);
    // Transfer ends inside records: first byte, middle, one byte short.
    queue_record(8'h01, 32'hCAFE_0001, 8'h08, '1, 32'h1, 1, 1'b1);
    queue_record(8'h01, 32'hCAFE_0002, 8'h08, '1, 32'h2, 7, 1'b1);
    queue_record(8'h01, 32'hCAFE_0003, 8'h08, '1, 32'h3, REC_BYTES - 1, 1'b1);
    queue_record(8'h03, 32'hCAFE_0004, 8'h08, 64'h0102_0304_0506_0708, 32'h4,
                 REC_BYTES, 1'b1);
    drain();

    write_filter(CFG_DROP_EXTENDED, 1'b1);
    write_filter(CFG_DROP_REMOTE, 1'b1);
    write_filter(CFG_DROP_STATUS, 1'b1);
    write_filter(CFG_INDEX_SPARE, 1'b0);
    queue_random_traffic(330);
    drain();

    write_filter(CFG_DROP_EXTENDED, 1'b0);
    write_filter(CFG_DROP_REMOTE, 1'b0);
    write_filter(CFG_DROP_STATUS, 1'b0);
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_requests <= hold_requests + 1;
    queue_random_traffic(330);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_filter(CFG_DROP_EXTENDED, 1'($urandom_range(0, 1)));
      write_filter(CFG_DROP_REMOTE, 1'($urandom_range(0, 1)));
      write_filter(CFG_DROP_STATUS, 1'($urandom_range(0, 1)));
      choice = $urandom_range(0, 2);
      send_gap_max = (choice == 0) ? 0 : (choice == 1) ? 3 : 12;
      choice = $urandom_range(0, 2);
      recv_gap_max = (choice == 0) ? 0 : (choice == 1) ? 3 : 12;
      queue_random_traffic(330);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/cusbrd_pkg.sv
rtl/core/cusbrd_assembler.sv
rtl/core/cusbrd_result.sv
rtl/core/can_usb_rx_record_decoder_core.sv
rtl/core/cusbrd_checker.sv
verif/can_usb_rx_record_decoder_core_test.sv
